[sv/pba_pkg.sv]
// Package for the power-of-two block allocator: widths, codes and state encodings.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package pba_pkg;
  localparam int MinSize     = 4;
  localparam int MaxSize     = 29;
  localparam int NumPools    = MaxSize - MinSize + 1;
  localparam int RootEntries = 64;
  localparam int RootIdxW    = $clog2(RootEntries);
  localparam int PoolIdxW    = $clog2(NumPools);

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_SLOTS = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;

  // Datapath commands.
  typedef struct packed {
    logic load;       // capture the input item
    logic simple;     // perform add, slots, clear or a rejected allocation and form result
    logic pool_try;   // try the pool at the current level
    logic scan_step;  // examine the fetched root entry
    logic climb;      // move up one level, rewind scan
    logic split;      // one split step downward
    logic fail;       // result is "nothing available"
    logic clear_step; // mark one root entry free
  } pba_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic bad_size;
    logic pool_hit;   // pool had a nonzero half
    logic scan_hit;   // fetched entry matches
    logic scan_end;   // scan index has reached root count
    logic top_level;  // current level is MaxSize
    logic at_target;  // current level equals requested size
    logic split_ok;   // at least two slots remain for a split
    logic split_zero; // the half a split would return is slot number zero
    logic is_clear;
    logic clear_end;
  } pba_sts_t;
endpackage
`default_nettype wire

[sv/power_of_two_block_allocator_unit.sv]
// Top level of the power-of-two block allocator: stream ports and output register.
// Depends on pba_pkg, pba_ctrl and pba_dp.
//
// Usage. One operation enters per transfer on the in_ channel and yields exactly
// one result transfer on the out_ channel. Operations: add a root block,
// allocate a block of a size class, bump-allocate contiguous slots, clear.
// The three slot registers are written through the cfg_ port; the user is to
// write them while the block is idle, which the block itself does not enforce.
// A write takes effect at the clock edge where cfg_we is high.
// Add, slot allocation and failed size checks go from the decode state
// straight to the output state. Clear walks the root table one entry a cycle.
// Allocation tries the pool and then scans the root table, fetching and then
// examining each entry, at each level it climbs; it then splits one level per
// cycle on the way down.
// One item is in work at a time; the block takes the next input once the
// result has been moved into the output register, so a stalled receiver holds
// at most one waiting result while the next item is already computed.
// Reset (rst_n low, synchronous) clears the registers, the slot counter, the
// pools and the root count; the output register is emptied.
`default_nettype none
module power_of_two_block_allocator_unit import pba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata fields from bit 0: func[1:0], handle_in[33:2], size_class[39:34],
  // slot_request[71:40]
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata fields from bit 0: value_out[31:0], status[33:32]
  output logic [39:0]      out_tdata
);
  pba_cmd_t    cmd;
  pba_sts_t    sts;
  logic        busy, res_done, in_fire, res_free;
  logic [31:0] res_value;
  logic [1:0]  res_status;
  logic        ovalid_r;
  logic [33:0] odata_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  // The output register is free when empty or being drained this cycle.
  assign res_free  = !ovalid_r || out_tready;

  pba_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .res_free, .sts, .cmd, .busy, .res_done
  );

  pba_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_func(in_tdata[1:0]), .in_handle(in_tdata[33:2]),
    .in_size(in_tdata[39:34]), .in_req(in_tdata[71:40]),
    .cmd, .sts, .res_value, .res_status
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (res_done) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) odata_r <= {res_status, res_value};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, odata_r};
endmodule
`default_nettype wire

[sv/pba_ctrl.sv]
// Controller state machine of the block allocator.
// Depends on pba_pkg; drives the datapath through pba_cmd_t.
`default_nettype none
module pba_ctrl import pba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire logic     res_free,
  input  pba_sts_t      sts,
  output pba_cmd_t      cmd,
  output logic          busy,
  output logic          res_done
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_POOL  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SPLIT = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    res_done  = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.is_alloc && !sts.bad_size) begin
          state_nxt = S_POOL;
        end else if (sts.is_clear) begin
          cmd.simple = 1'b1;
          state_nxt  = S_CLR;
        end else begin
          cmd.simple = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_POOL: begin
        cmd.pool_try = 1'b1;
        if (sts.pool_hit) state_nxt = S_SPLIT;
        else              state_nxt = S_FETCH;
      end
      // The root entry at the scan index is read here and examined next cycle.
      S_FETCH: begin
        if (sts.scan_end) begin
          if (sts.top_level) begin
            cmd.fail  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.climb = 1'b1;
            state_nxt = S_POOL;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) state_nxt = S_SPLIT;
        else              state_nxt = S_FETCH;
      end
      S_SPLIT: begin
        if (sts.at_target) begin
          state_nxt = S_OUT;
        end else if (!sts.split_ok) begin
          cmd.fail  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.split = 1'b1;
          if (sts.split_zero) state_nxt = S_OUT;
        end
      end
      S_CLR: begin
        if (sts.clear_end) state_nxt = S_OUT;
        else               cmd.clear_step = 1'b1;
      end
      S_OUT: begin
        if (res_free) begin
          res_done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule
`default_nettype wire

[sv/pba_dp.sv]
// Datapath of the block allocator: pools, root table, slot counter and result.
// Depends on pba_pkg; commanded by pba_ctrl.
`default_nettype none
module pba_dp import pba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_handle,
  input  wire logic [5:0]  in_size,
  input  wire logic [31:0] in_req,
  input  pba_cmd_t         cmd,
  output pba_sts_t         sts,
  output logic [31:0]      res_value,
  output logic [1:0]       res_status
);
  logic [31:0] base_r, total_r, offset_r, used_r;
  logic [31:0] pool_base_r [NumPools];
  logic [1:0]  pool_left_r [NumPools];
  logic [31:0] root_handle_m [RootEntries];
  logic [5:0]  root_size_m   [RootEntries];
  logic        root_free_m   [RootEntries];
  logic [31:0] rd_handle_r;
  logic [5:0]  rd_size_r;
  logic        rd_free_r;
  logic [RootIdxW:0] root_count_r, idx_r;
  logic [1:0]  func_r;
  logic [31:0] handle_r, req_r, val_r;
  logic [5:0]  size_r, lvl_r;
  logic [1:0]  st_r;

  logic [PoolIdxW-1:0] pidx, pidx_dn;
  logic [31:0] avail, next_slot, pool_v, split_v;
  logic [5:0]  lvl_dn;
  logic        size_bad;

  function automatic logic in_ok();
    in_ok = (handle_r != 32'd0) && !size_bad &&
            (root_count_r < (RootIdxW+1)'(RootEntries));
  endfunction

  assign size_bad  = (size_r < 6'(MinSize)) || (size_r > 6'(MaxSize));
  assign pidx      = PoolIdxW'(lvl_r - 6'(MinSize));
  assign lvl_dn    = lvl_r - 6'd1;
  assign pidx_dn   = PoolIdxW'(lvl_dn - 6'(MinSize));
  assign avail     = (used_r >= total_r) ? 32'd0 : total_r - used_r;
  assign next_slot = base_r + used_r + offset_r;
  assign pool_v    = pool_base_r[pidx] + 32'(pool_left_r[pidx] - 2'd1);
  assign split_v   = next_slot + 32'd1;

  assign sts.is_alloc   = (func_r == FUNC_ALLOC);
  assign sts.is_clear   = (func_r == FUNC_CLEAR);
  assign sts.bad_size   = size_bad;
  assign sts.pool_hit   = (pool_left_r[pidx] != 2'd0) && (pool_v != 32'd0);
  assign sts.scan_end   = (idx_r >= root_count_r);
  assign sts.scan_hit   = rd_free_r && (rd_size_r == lvl_r);
  assign sts.top_level  = (lvl_r == 6'(MaxSize));
  assign sts.at_target  = (lvl_r == size_r);
  assign sts.split_ok   = (avail >= 32'd2);
  assign sts.split_zero = (split_v == 32'd0);
  assign sts.clear_end  = (idx_r >= root_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; total_r <= '0; offset_r <= '0; used_r <= '0;
      root_count_r <= '0;
      for (int i = 0; i < NumPools; i++) begin
        pool_base_r[i] <= '0;
        pool_left_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BASE:   base_r   <= cfg_wdata;
          CFG_TOTAL:  total_r  <= cfg_wdata;
          CFG_OFFSET: offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.simple) begin
        case (func_r)
          FUNC_ADD: if (in_ok()) root_count_r <= root_count_r + 1'b1;
          FUNC_SLOTS: if (req_r <= avail) used_r <= used_r + req_r;
          FUNC_CLEAR: begin
            used_r <= '0;
            for (int i = 0; i < NumPools; i++) begin
              pool_base_r[i] <= '0;
              pool_left_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.pool_try && pool_left_r[pidx] != 2'd0)
        pool_left_r[pidx] <= pool_left_r[pidx] - 2'd1;
      if (cmd.split) begin
        pool_base_r[pidx_dn] <= next_slot;
        pool_left_r[pidx_dn] <= 2'd1;
        used_r <= used_r + 32'd2;
      end
    end
  end

  // Root table storage with one registered read a cycle at the scan index;
  // entries are only meaningful below root_count.
  always_ff @(posedge clk) begin
    if (cmd.simple && func_r == FUNC_ADD && in_ok()) begin
      root_handle_m[root_count_r[RootIdxW-1:0]] <= handle_r;
      root_size_m[root_count_r[RootIdxW-1:0]]   <= size_r;
      root_free_m[root_count_r[RootIdxW-1:0]]   <= 1'b1;
    end
    if (cmd.scan_step && sts.scan_hit)
      root_free_m[idx_r[RootIdxW-1:0]] <= 1'b0;
    if (cmd.clear_step)
      root_free_m[idx_r[RootIdxW-1:0]] <= 1'b1;
    rd_handle_r <= root_handle_m[idx_r[RootIdxW-1:0]];
    rd_size_r   <= root_size_m[idx_r[RootIdxW-1:0]];
    rd_free_r   <= root_free_m[idx_r[RootIdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func; handle_r <= in_handle; size_r <= in_size;
      req_r <= in_req; lvl_r <= in_size; idx_r <= '0;
      val_r <= '0; st_r <= ST_OK;
    end
    if (cmd.simple) begin
      case (func_r)
        FUNC_ADD: begin
          val_r <= in_ok() ? handle_r : 32'd0;
          st_r  <= in_ok() ? ST_OK : ST_REJECT;
        end
        FUNC_ALLOC: begin val_r <= '0; st_r <= ST_REJECT; end
        FUNC_SLOTS: begin
          val_r <= (req_r <= avail) ? next_slot : 32'd0;
          st_r  <= (req_r <= avail) ? ST_OK : ST_NONE;
        end
        FUNC_CLEAR: begin val_r <= '0; st_r <= ST_OK; end
        default: ;
      endcase
    end
    if (cmd.pool_try && sts.pool_hit) val_r <= pool_v;
    if (cmd.scan_step) begin
      if (sts.scan_hit) val_r <= rd_handle_r;
      else idx_r <= idx_r + 1'b1;
    end
    if (cmd.climb) begin
      lvl_r <= lvl_r + 6'd1;
      idx_r <= '0;
    end
    // A split whose returned half is slot zero fails; the slots stay used.
    if (cmd.split) begin
      lvl_r <= lvl_dn;
      val_r <= split_v;
      if (split_v == 32'd0) st_r <= ST_NONE;
    end
    if (cmd.clear_step) idx_r <= idx_r + 1'b1;
    if (cmd.fail) begin
      val_r <= '0;
      st_r  <= ST_NONE;
    end
  end

  assign res_value  = val_r;
  assign res_status = st_r;
endmodule
`default_nettype wire
